### hdl/rds_pkg.sv
// Shared codes, field widths and reset values for the defrost sequencer.
// No dependencies; used by the channel interfaces, the top level and the checker.
package rds_pkg;

  localparam int unsigned ElapsedW   = 16;
  localparam int unsigned TempW      = 12;
  localparam int unsigned PhaseW     = 3;
  localparam int unsigned SecondsW   = 23;
  localparam int unsigned CauseW     = 2;
  localparam int unsigned CountW     = 16;
  localparam int unsigned StreakW    = 8;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned TimerW     = 32;
  localparam int unsigned SlotW      = 12;

  typedef logic [PhaseW-1:0] phase_t;

  localparam phase_t PhIdle   = 3'd0;
  localparam phase_t PhStab   = 3'd1;
  localparam phase_t PhValve  = 3'd2;
  localparam phase_t PhActive = 3'd3;
  localparam phase_t PhEqual  = 3'd4;
  localparam phase_t PhDrip   = 3'd5;
  localparam phase_t PhFan    = 3'd6;

  localparam logic [1:0] KindNatural = 2'd0;
  localparam logic [1:0] KindHeater  = 2'd1;
  localparam logic [1:0] KindHotGas  = 2'd2;

  localparam logic [1:0] CountRealTime = 2'd1;

  localparam logic [1:0] StartTimer  = 2'd0;
  localparam logic [1:0] StartDemand = 2'd1;
  localparam logic [1:0] StartBoth   = 2'd2;
  localparam logic [1:0] StartNone   = 2'd3;

  localparam logic [CauseW-1:0] CauseNone    = 2'd0;
  localparam logic [CauseW-1:0] CauseTemp    = 2'd1;
  localparam logic [CauseW-1:0] CauseTimeout = 2'd2;

  localparam logic [CfgIndexW-1:0] CfgKind      = 3'd0;
  localparam logic [CfgIndexW-1:0] CfgCountMode = 3'd1;
  localparam logic [CfgIndexW-1:0] CfgStartMode = 3'd2;
  localparam logic [CfgIndexW-1:0] CfgEndThr    = 3'd3;
  localparam logic [CfgIndexW-1:0] CfgDemandThr = 3'd4;
  localparam logic [CfgIndexW-1:0] CfgFanThr    = 3'd5;
  localparam logic [CfgIndexW-1:0] CfgLongTimes = 3'd6;
  localparam logic [CfgIndexW-1:0] CfgPhaseSec  = 3'd7;

  localparam logic [1:0]        KindRst      = KindNatural;
  localparam logic [1:0]        CountModeRst = CountRealTime;
  localparam logic [1:0]        StartModeRst = StartTimer;
  localparam logic signed [11:0] EndThrRst    = 12'sd80;
  localparam logic signed [11:0] DemandThrRst = -12'sd250;
  localparam logic signed [11:0] FanThrRst    = -12'sd50;
  localparam logic [63:0]       LongTimesRst = 64'd7730941161600000;
  localparam logic [59:0]       PhaseSecRst  = 60'd33785245052448798;

  localparam logic [StreakW-1:0] AlarmStreak = 8'd3;

  // floor(x / 1000) for any 32-bit x is (x * Div1000Magic) >> Div1000Shift
  localparam int unsigned   MagicW       = 29;
  localparam logic [28:0]   Div1000Magic = 29'h10624DD3;
  localparam int unsigned   Div1000Shift = 38;
  localparam logic [9:0]    MsPerSecond  = 10'd1000;

endpackage

### hdl/rds_if.sv
// Input and result channel interfaces of the defrost sequencer.
// Depends on rds_pkg for field widths.
interface rds_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [rds_pkg::ElapsedW-1:0]         elapsed_ms;
  logic signed [rds_pkg::TempW-1:0]     evap_temperature;
  logic                                 evap_sensor_good;
  logic                                 compressor_running;
  logic                                 protection_lockout;
  logic                                 manual_request;

  modport source (
    output valid, elapsed_ms, evap_temperature, evap_sensor_good,
           compressor_running, protection_lockout, manual_request,
    input  ready
  );
  modport sink (
    input  valid, elapsed_ms, evap_temperature, evap_sensor_good,
           compressor_running, protection_lockout, manual_request,
    output ready
  );
endinterface

interface rds_out_if;
  logic                              valid;
  logic                              ready;
  logic [rds_pkg::PhaseW-1:0]        phase_code;
  logic                              defrost_running;
  logic                              want_compressor;
  logic                              want_heater;
  logic                              want_condenser_fan;
  logic                              want_gas_valve;
  logic [rds_pkg::SecondsW-1:0]      phase_elapsed_s;
  logic [rds_pkg::SecondsW-1:0]      interval_elapsed_s;
  logic [rds_pkg::CauseW-1:0]        end_cause;
  logic [rds_pkg::CountW-1:0]        cycles_done;
  logic [rds_pkg::StreakW-1:0]       timeouts_in_row;
  logic                              timeout_alarm;

  modport source (
    output valid, phase_code, defrost_running, want_compressor, want_heater,
           want_condenser_fan, want_gas_valve, phase_elapsed_s, interval_elapsed_s,
           end_cause, cycles_done, timeouts_in_row, timeout_alarm,
    input  ready
  );
  modport sink (
    input  valid, phase_code, defrost_running, want_compressor, want_heater,
           want_condenser_fan, want_gas_valve, phase_elapsed_s, interval_elapsed_s,
           end_cause, cycles_done, timeouts_in_row, timeout_alarm,
    output ready
  );
endinterface

### hdl/refrigeration_defrost_sequencer_unit.sv
// Top level of the refrigeration defrost sequencer: phase state, timers, relay requests.
// Depends on rds_pkg and the channel interfaces in rds_if.sv.
//
//   channel  direction  handshake      contents
//   in_ch    sink       valid/ready    elapsed time, evaporator reading, flags
//   out_ch   source     valid/ready    phase, relay requests, timers, counters
//   cfg_*    sink       cfg_we only    register index and write data
//
// One transaction per cycle sustained while out_ch.ready is high; a transaction passes
// the snapshot stage and the output registers before out_ch.valid rises. The phase update
// is combinational ahead of the snapshot stage; the 32x29 reciprocal multiply that turns
// milliseconds into seconds feeds the output registers. rst_n is synchronous; it clears
// phase state, timers, counters and both stage valids, and loads register defaults.
// A stalled output keeps its transaction; the snapshot stage still takes one more behind it.
module refrigeration_defrost_sequencer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rds_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [rds_pkg::CfgDataW-1:0]       cfg_data,
  rds_in_if.sink                             in_ch,
  rds_out_if.source                          out_ch
);

  logic [1:0]                       kind_r;
  logic [1:0]                       count_mode_r;
  logic [1:0]                       start_mode_r;
  logic signed [rds_pkg::TempW-1:0] end_thr_r;
  logic signed [rds_pkg::TempW-1:0] dem_thr_r;
  logic signed [rds_pkg::TempW-1:0] fan_thr_r;
  logic [63:0]                      long_times_r;
  logic [59:0]                      phase_sec_r;

  rds_pkg::phase_t                  phase_r, phase_nxt;
  logic [rds_pkg::TimerW-1:0]       ptimer_r, ptimer_nxt;
  logic [rds_pkg::TimerW-1:0]       itimer_r, itimer_nxt;
  logic [rds_pkg::CountW-1:0]       done_r, done_nxt;
  logic [rds_pkg::StreakW-1:0]      streak_r, streak_nxt;
  logic [rds_pkg::CauseW-1:0]       cause_r, cause_nxt;

  logic                             s1_valid_r;
  rds_pkg::phase_t                  s1_phase_r;
  logic [rds_pkg::TimerW-1:0]       s1_ptimer_r;
  logic [rds_pkg::TimerW-1:0]       s1_itimer_r;
  logic [rds_pkg::CountW-1:0]       s1_done_r;
  logic [rds_pkg::StreakW-1:0]      s1_streak_r;
  logic [rds_pkg::CauseW-1:0]       s1_cause_r;

  logic                             out_valid_r;
  rds_pkg::phase_t                  out_phase_r;
  logic                             out_comp_r;
  logic                             out_heater_r;
  logic                             out_cfan_r;
  logic                             out_valve_r;
  logic [rds_pkg::SecondsW-1:0]     out_psec_r;
  logic [rds_pkg::SecondsW-1:0]     out_isec_r;
  logic [rds_pkg::CauseW-1:0]       out_cause_r;
  logic [rds_pkg::CountW-1:0]       out_done_r;
  logic [rds_pkg::StreakW-1:0]      out_streak_r;

  logic                             in_fire;
  logic                             out_load;

  logic signed [rds_pkg::TempW-1:0] evap;
  logic                             ok;
  logic                             idle_now;
  logic                             gas_kind;
  logic [rds_pkg::TimerW-1:0]       pt_add;
  logic [rds_pkg::TimerW-1:0]       it_add;
  logic [rds_pkg::TimerW-1:0]       interval_ms;
  logic [rds_pkg::TimerW-1:0]       max_ms;
  logic                             by_timer;
  logic                             by_demand;
  rds_pkg::phase_t                  start_phase;
  rds_pkg::phase_t                  after_active;
  logic [rds_pkg::CountW-1:0]       done_inc;
  logic                             s1_active_gas;

  function automatic logic [rds_pkg::TimerW-1:0] sat_add(
    input logic [rds_pkg::TimerW-1:0]   a,
    input logic [rds_pkg::ElapsedW-1:0] b
  );
    logic [rds_pkg::TimerW:0] s;
    s = {1'b0, a} + {{(rds_pkg::TimerW + 1 - rds_pkg::ElapsedW){1'b0}}, b};
    return s[rds_pkg::TimerW] ? {rds_pkg::TimerW{1'b1}} : s[rds_pkg::TimerW-1:0];
  endfunction

  function automatic logic [rds_pkg::TimerW-1:0] limit_ms(
    input logic [rds_pkg::SlotW-1:0] secs
  );
    logic [rds_pkg::TimerW-1:0] w;
    w = {{(rds_pkg::TimerW - rds_pkg::SlotW){1'b0}}, secs};
    return w * {{(rds_pkg::TimerW - 10){1'b0}}, rds_pkg::MsPerSecond};
  endfunction

  function automatic logic [rds_pkg::SecondsW-1:0] to_seconds(
    input logic [rds_pkg::TimerW-1:0] ms
  );
    logic [rds_pkg::TimerW+rds_pkg::MagicW-1:0] prod;
    prod = {{rds_pkg::MagicW{1'b0}}, ms}
         * {{rds_pkg::TimerW{1'b0}}, rds_pkg::Div1000Magic};
    return prod[rds_pkg::Div1000Shift +: rds_pkg::SecondsW];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r       <= rds_pkg::KindRst;
      count_mode_r <= rds_pkg::CountModeRst;
      start_mode_r <= rds_pkg::StartModeRst;
      end_thr_r    <= rds_pkg::EndThrRst;
      dem_thr_r    <= rds_pkg::DemandThrRst;
      fan_thr_r    <= rds_pkg::FanThrRst;
      long_times_r <= rds_pkg::LongTimesRst;
      phase_sec_r  <= rds_pkg::PhaseSecRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rds_pkg::CfgKind:      kind_r       <= cfg_data[1:0];
        rds_pkg::CfgCountMode: count_mode_r <= cfg_data[1:0];
        rds_pkg::CfgStartMode: start_mode_r <= cfg_data[1:0];
        rds_pkg::CfgEndThr:    end_thr_r    <= cfg_data[rds_pkg::TempW-1:0];
        rds_pkg::CfgDemandThr: dem_thr_r    <= cfg_data[rds_pkg::TempW-1:0];
        rds_pkg::CfgFanThr:    fan_thr_r    <= cfg_data[rds_pkg::TempW-1:0];
        rds_pkg::CfgLongTimes: long_times_r <= cfg_data;
        rds_pkg::CfgPhaseSec:  phase_sec_r  <= cfg_data[59:0];
        default: ;
      endcase
    end
  end

  assign out_load    = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || out_load;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign evap         = in_ch.evap_temperature;
  assign ok           = in_ch.evap_sensor_good;
  assign idle_now     = (phase_r == rds_pkg::PhIdle) || (phase_r > rds_pkg::PhFan);
  assign gas_kind     = (kind_r == rds_pkg::KindHotGas);
  assign pt_add       = sat_add(ptimer_r, in_ch.elapsed_ms);
  assign interval_ms  = long_times_r[31:0];
  assign max_ms       = long_times_r[63:32];
  assign start_phase  = gas_kind ? rds_pkg::PhStab : rds_pkg::PhActive;
  assign after_active = gas_kind ? rds_pkg::PhEqual : rds_pkg::PhDrip;
  assign done_inc     = (done_r != {rds_pkg::CountW{1'b1}}) ? done_r + 1'b1 : done_r;
  assign it_add       = (count_mode_r == rds_pkg::CountRealTime || in_ch.compressor_running)
                      ? sat_add(itimer_r, in_ch.elapsed_ms) : itimer_r;
  assign by_timer     = (start_mode_r == rds_pkg::StartTimer ||
                         start_mode_r == rds_pkg::StartBoth) && (it_add >= interval_ms);
  assign by_demand    = (start_mode_r == rds_pkg::StartDemand ||
                         start_mode_r == rds_pkg::StartBoth) && ok && (evap < dem_thr_r);

  always_comb begin
    phase_nxt  = phase_r;
    ptimer_nxt = ptimer_r;
    itimer_nxt = itimer_r;
    done_nxt   = done_r;
    streak_nxt = streak_r;
    cause_nxt  = cause_r;
    if (in_ch.protection_lockout && !idle_now) begin
      phase_nxt  = rds_pkg::PhIdle;
      ptimer_nxt = '0;
    end else begin
      unique case (phase_r)
        rds_pkg::PhStab: begin
          ptimer_nxt = pt_add;
          if (pt_add >= limit_ms(phase_sec_r[0 +: rds_pkg::SlotW])) begin
            phase_nxt  = rds_pkg::PhValve;
            ptimer_nxt = '0;
          end
        end
        rds_pkg::PhValve: begin
          ptimer_nxt = pt_add;
          if (pt_add >= limit_ms(phase_sec_r[rds_pkg::SlotW +: rds_pkg::SlotW])) begin
            phase_nxt  = rds_pkg::PhActive;
            ptimer_nxt = '0;
          end
        end
        rds_pkg::PhActive: begin
          ptimer_nxt = pt_add;
          if (ok && evap >= end_thr_r) begin
            streak_nxt = '0;
            cause_nxt  = rds_pkg::CauseTemp;
            done_nxt   = done_inc;
            phase_nxt  = after_active;
            ptimer_nxt = '0;
          end else if (pt_add >= max_ms) begin
            streak_nxt = (streak_r != {rds_pkg::StreakW{1'b1}}) ? streak_r + 1'b1 : streak_r;
            cause_nxt  = rds_pkg::CauseTimeout;
            done_nxt   = done_inc;
            phase_nxt  = after_active;
            ptimer_nxt = '0;
          end
        end
        rds_pkg::PhEqual: begin
          ptimer_nxt = pt_add;
          if (pt_add >= limit_ms(phase_sec_r[2*rds_pkg::SlotW +: rds_pkg::SlotW])) begin
            phase_nxt  = rds_pkg::PhDrip;
            ptimer_nxt = '0;
          end
        end
        rds_pkg::PhDrip: begin
          ptimer_nxt = pt_add;
          if (pt_add >= limit_ms(phase_sec_r[3*rds_pkg::SlotW +: rds_pkg::SlotW])) begin
            phase_nxt  = rds_pkg::PhFan;
            ptimer_nxt = '0;
          end
        end
        rds_pkg::PhFan: begin
          ptimer_nxt = pt_add;
          if ((ok && evap < fan_thr_r) ||
              pt_add >= limit_ms(phase_sec_r[4*rds_pkg::SlotW +: rds_pkg::SlotW])) begin
            phase_nxt  = rds_pkg::PhIdle;
            ptimer_nxt = '0;
          end
        end
        default: begin
          phase_nxt = rds_pkg::PhIdle;
          if (in_ch.manual_request) begin
            itimer_nxt = '0;
            phase_nxt  = start_phase;
            ptimer_nxt = '0;
          end else if (start_mode_r != rds_pkg::StartNone) begin
            itimer_nxt = it_add;
            if (by_timer || by_demand) begin
              itimer_nxt = '0;
              if (!(ok && evap > end_thr_r)) begin
                phase_nxt  = start_phase;
                ptimer_nxt = '0;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rds_pkg::PhIdle;
      ptimer_r <= '0;
      itimer_r <= '0;
      done_r   <= '0;
      streak_r <= '0;
      cause_r  <= rds_pkg::CauseNone;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      ptimer_r <= ptimer_nxt;
      itimer_r <= itimer_nxt;
      done_r   <= done_nxt;
      streak_r <= streak_nxt;
      cause_r  <= cause_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_phase_r  <= phase_nxt;
      s1_ptimer_r <= ptimer_nxt;
      s1_itimer_r <= itimer_nxt;
      s1_done_r   <= done_nxt;
      s1_streak_r <= streak_nxt;
      s1_cause_r  <= cause_nxt;
    end
  end

  assign s1_active_gas = (s1_phase_r == rds_pkg::PhActive) && (kind_r >= rds_pkg::KindHotGas);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_phase_r  <= s1_phase_r;
      out_comp_r   <= s1_active_gas || (s1_phase_r == rds_pkg::PhFan);
      out_heater_r <= (s1_phase_r == rds_pkg::PhActive) && (kind_r == rds_pkg::KindHeater);
      out_cfan_r   <= (s1_phase_r == rds_pkg::PhFan);
      out_valve_r  <= s1_active_gas || (s1_phase_r == rds_pkg::PhValve);
      out_psec_r   <= to_seconds(s1_ptimer_r);
      out_isec_r   <= to_seconds(s1_itimer_r);
      out_cause_r  <= s1_cause_r;
      out_done_r   <= s1_done_r;
      out_streak_r <= s1_streak_r;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.phase_code         = out_phase_r;
  assign out_ch.defrost_running    = (out_phase_r != rds_pkg::PhIdle);
  assign out_ch.want_compressor    = out_comp_r;
  assign out_ch.want_heater        = out_heater_r;
  assign out_ch.want_condenser_fan = out_cfan_r;
  assign out_ch.want_gas_valve     = out_valve_r;
  assign out_ch.phase_elapsed_s    = out_psec_r;
  assign out_ch.interval_elapsed_s = out_isec_r;
  assign out_ch.end_cause          = out_cause_r;
  assign out_ch.cycles_done        = out_done_r;
  assign out_ch.timeouts_in_row    = out_streak_r;
  assign out_ch.timeout_alarm      = (out_streak_r >= rds_pkg::AlarmStreak);

endmodule

### hdl/rds_checker.sv
// Port-level checks on the result channel of the defrost sequencer, bound to the top level.
// Depends on rds_pkg for phase codes and field widths.
module rds_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rds_pkg::PhaseW-1:0]    phase_code,
  input logic                          defrost_running,
  input logic                          want_heater,
  input logic                          want_gas_valve,
  input logic                          want_condenser_fan,
  input logic [rds_pkg::StreakW-1:0]   timeouts_in_row,
  input logic                          timeout_alarm
);

  // hold a stalled transaction
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(phase_code) &&
                                $stable(timeouts_in_row))
    else $error("stalled result transaction changed");

  a_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> defrost_running == (phase_code != rds_pkg::PhIdle))
    else $error("defrost_running disagrees with phase_code");

  a_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> timeout_alarm == (timeouts_in_row >= rds_pkg::AlarmStreak))
    else $error("timeout_alarm disagrees with timeouts_in_row");

  a_heater: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && want_heater |-> phase_code == rds_pkg::PhActive && !want_gas_valve)
    else $error("heater requested outside heater active phase");

  a_cond_fan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> want_condenser_fan == (phase_code == rds_pkg::PhFan))
    else $error("condenser fan request disagrees with phase_code");

endmodule

bind refrigeration_defrost_sequencer_unit rds_checker u_rds_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .phase_code         (out_ch.phase_code),
  .defrost_running    (out_ch.defrost_running),
  .want_heater        (out_ch.want_heater),
  .want_gas_valve     (out_ch.want_gas_valve),
  .want_condenser_fan (out_ch.want_condenser_fan),
  .timeouts_in_row    (out_ch.timeouts_in_row),
  .timeout_alarm      (out_ch.timeout_alarm)
);

### sim/refrigeration_defrost_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the defrost sequencer: a stimulus table, a timeout-streak run and random
// ticks, each result checked against an in-bench phase model or a typed row. Needs rds_pkg, rds_if and the top.
module refrigeration_defrost_sequencer_unit_tb;

  localparam int unsigned     CycleLimit      = 2000000;
  localparam int unsigned     MaxPrinted      = 40;
  localparam logic [1:0]      KindSpare       = 2'd3;
  localparam logic [1:0]      CountCompressor = 2'd2;

  typedef struct packed {
    logic [15:0] dt;
    logic [11:0] temp;
    logic        sensor_ok;
    logic        comp_on;
    logic        lockout;
    logic        manual;
  } tick_t;

  typedef struct packed {
    rds_pkg::phase_t phase;
    logic        running;
    logic        want_comp;
    logic        want_heat;
    logic        want_cfan;
    logic        want_valve;
    logic [22:0] phase_s;
    logic [22:0] intv_s;
    logic [1:0]  cause;
    logic [15:0] done;
    logic [7:0]  streak;
    logic        alarm;
  } status_t;

  typedef struct packed {
    logic           is_write;
    logic [2:0]     reg_idx;
    logic [63:0]    reg_val;
    tick_t          tick;
    logic           typed;
    status_t        want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [rds_pkg::CfgIndexW-1:0] cfg_index;
  logic [rds_pkg::CfgDataW-1:0]  cfg_data;

  rds_in_if  in_ch();
  rds_out_if out_ch();

  refrigeration_defrost_sequencer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadow
  logic [1:0]  kind       = rds_pkg::KindRst;
  logic [1:0]  count_mode = rds_pkg::CountModeRst;
  logic [1:0]  start_mode = rds_pkg::StartModeRst;
  logic [11:0] end_thr    = rds_pkg::EndThrRst;
  logic [11:0] dem_thr    = rds_pkg::DemandThrRst;
  logic [11:0] fan_thr    = rds_pkg::FanThrRst;
  logic [63:0] long_times = rds_pkg::LongTimesRst;
  logic [59:0] phase_sec  = rds_pkg::PhaseSecRst;

  // sequencer state
  rds_pkg::phase_t ph   = rds_pkg::PhIdle;
  logic [31:0] ph_ms    = '0;
  logic [31:0] intv_ms  = '0;
  logic [15:0] done_cnt = '0;
  logic [7:0]  streak   = '0;
  logic [1:0]  cause    = rds_pkg::CauseNone;

  status_t     expected_status[$];
  script_row_t script[$];

  int unsigned send_max = 13;
  int unsigned sink_max = 13;
  int unsigned sink_hold = 0;
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned ticks_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned cycle_count = 0;
  logic [6:0]  phase_seen = '0;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] slot_ms(int slot);
    return {20'd0, phase_sec[12*slot +: 12]} * 32'd1000;
  endfunction

  function automatic void move_to_phase(rds_pkg::phase_t p);
    ph = p;
    ph_ms = '0;
  endfunction

  function automatic void begin_cycle();
    intv_ms = '0;
    move_to_phase((kind == rds_pkg::KindHotGas) ? rds_pkg::PhStab : rds_pkg::PhActive);
  endfunction

  function automatic void close_active();
    if (done_cnt != 16'hFFFF) done_cnt = done_cnt + 16'd1;
    move_to_phase((kind == rds_pkg::KindHotGas) ? rds_pkg::PhEqual : rds_pkg::PhDrip);
  endfunction

  function automatic status_t advance_sequencer(tick_t t);
    status_t s;
    int evap;
    int t_end;
    int t_dem;
    int t_fan;
    logic by_timer;
    logic by_demand;
    evap  = $signed(t.temp);
    t_end = $signed(end_thr);
    t_dem = $signed(dem_thr);
    t_fan = $signed(fan_thr);
    if (t.lockout && ph != rds_pkg::PhIdle) begin
      move_to_phase(rds_pkg::PhIdle);
    end else begin
      case (ph)
        rds_pkg::PhStab: begin
          ph_ms = sat_add(ph_ms, t.dt);
          if (ph_ms >= slot_ms(0)) move_to_phase(rds_pkg::PhValve);
        end
        rds_pkg::PhValve: begin
          ph_ms = sat_add(ph_ms, t.dt);
          if (ph_ms >= slot_ms(1)) move_to_phase(rds_pkg::PhActive);
        end
        rds_pkg::PhActive: begin
          ph_ms = sat_add(ph_ms, t.dt);
          if (t.sensor_ok && evap >= t_end) begin
            streak = '0;
            cause = rds_pkg::CauseTemp;
            close_active();
          end else if (ph_ms >= long_times[63:32]) begin
            if (streak != 8'hFF) streak = streak + 8'd1;
            cause = rds_pkg::CauseTimeout;
            close_active();
          end
        end
        rds_pkg::PhEqual: begin
          ph_ms = sat_add(ph_ms, t.dt);
          if (ph_ms >= slot_ms(2)) move_to_phase(rds_pkg::PhDrip);
        end
        rds_pkg::PhDrip: begin
          ph_ms = sat_add(ph_ms, t.dt);
          if (ph_ms >= slot_ms(3)) move_to_phase(rds_pkg::PhFan);
        end
        rds_pkg::PhFan: begin
          ph_ms = sat_add(ph_ms, t.dt);
          if ((t.sensor_ok && evap < t_fan) || ph_ms >= slot_ms(4))
            move_to_phase(rds_pkg::PhIdle);
        end
        default: begin
          if (t.manual) begin
            begin_cycle();
          end else if (start_mode != rds_pkg::StartNone) begin
            if (count_mode == rds_pkg::CountRealTime || t.comp_on)
              intv_ms = sat_add(intv_ms, t.dt);
            by_timer = (start_mode == rds_pkg::StartTimer || start_mode == rds_pkg::StartBoth) &&
                       intv_ms >= long_times[31:0];
            by_demand = (start_mode == rds_pkg::StartDemand ||
                         start_mode == rds_pkg::StartBoth) && t.sensor_ok && evap < t_dem;
            if (by_timer || by_demand) begin
              if (t.sensor_ok && evap > t_end) intv_ms = '0;
              else begin_cycle();
            end
          end
        end
      endcase
    end
    s.phase      = ph;
    s.running    = (ph != rds_pkg::PhIdle);
    s.want_comp  = (ph == rds_pkg::PhActive && kind >= rds_pkg::KindHotGas) ||
                   ph == rds_pkg::PhFan;
    s.want_heat  = (ph == rds_pkg::PhActive && kind == rds_pkg::KindHeater);
    s.want_cfan  = (ph == rds_pkg::PhFan);
    s.want_valve = (ph == rds_pkg::PhValve) ||
                   (ph == rds_pkg::PhActive && kind >= rds_pkg::KindHotGas);
    s.phase_s    = 23'(ph_ms / 32'd1000);
    s.intv_s     = 23'(intv_ms / 32'd1000);
    s.cause      = cause;
    s.done       = done_cnt;
    s.streak     = streak;
    s.alarm      = (streak >= rds_pkg::AlarmStreak);
    return s;
  endfunction

  function automatic tick_t mk_tick(int dt, int temp, bit ok, bit comp, bit lock, bit man);
    tick_t t;
    t.dt        = 16'(dt);
    t.temp      = 12'(temp);
    t.sensor_ok = ok;
    t.comp_on   = comp;
    t.lockout   = lock;
    t.manual    = man;
    return t;
  endfunction

  function automatic script_row_t tick_row(tick_t t);
    script_row_t r;
    r = '0;
    r.tick = t;
    return r;
  endfunction

  function automatic script_row_t typed_row(tick_t t, rds_pkg::phase_t p, int intv_s,
                                            logic [1:0] c, int done);
    script_row_t r;
    r = tick_row(t);
    r.typed        = 1'b1;
    r.want.phase   = p;
    r.want.running = (p != rds_pkg::PhIdle);
    r.want.intv_s  = 23'(intv_s);
    r.want.cause   = c;
    r.want.done    = 16'(done);
    return r;
  endfunction

  function automatic script_row_t write_row(logic [2:0] idx, logic [63:0] val);
    script_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.reg_val  = val;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("mismatch at result %0d: %s", results_checked, what);
  endtask

  task automatic check_field(string name, longint unsigned got, longint unsigned want);
    if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic check_status(status_t got, status_t want);
    check_field("phase_code", got.phase, want.phase);
    check_field("defrost_running", got.running, want.running);
    check_field("want_compressor", got.want_comp, want.want_comp);
    check_field("want_heater", got.want_heat, want.want_heat);
    check_field("want_condenser_fan", got.want_cfan, want.want_cfan);
    check_field("want_gas_valve", got.want_valve, want.want_valve);
    check_field("phase_elapsed_s", got.phase_s, want.phase_s);
    check_field("interval_elapsed_s", got.intv_s, want.intv_s);
    check_field("end_cause", got.cause, want.cause);
    check_field("cycles_done", got.done, want.done);
    check_field("timeouts_in_row", got.streak, want.streak);
    check_field("timeout_alarm", got.alarm, want.alarm);
  endtask

  task automatic send_tick(tick_t t, bit typed, status_t want);
    int unsigned gap;
    status_t predicted;
    gap = $urandom_range(0, send_max);
    if (gap != 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid              <= 1'b1;
    in_ch.elapsed_ms         <= t.dt;
    in_ch.evap_temperature   <= t.temp;
    in_ch.evap_sensor_good   <= t.sensor_ok;
    in_ch.compressor_running <= t.comp_on;
    in_ch.protection_lockout <= t.lockout;
    in_ch.manual_request     <= t.manual;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = advance_sequencer(t);
    expected_status.push_back(typed ? want : predicted);
    ticks_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      rds_pkg::CfgKind:      kind       = val[1:0];
      rds_pkg::CfgCountMode: count_mode = val[1:0];
      rds_pkg::CfgStartMode: start_mode = val[1:0];
      rds_pkg::CfgEndThr:    end_thr    = val[11:0];
      rds_pkg::CfgDemandThr: dem_thr    = val[11:0];
      rds_pkg::CfgFanThr:    fan_thr    = val[11:0];
      rds_pkg::CfgLongTimes: long_times = val;
      rds_pkg::CfgPhaseSec:  phase_sec  = val[59:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_settings();
    logic [31:0] interval_ms;
    logic [31:0] active_ms;
    logic [59:0] secs;
    logic [11:0] thr;
    case ($urandom_range(0, 5))
      0:       interval_ms = '0;
      1:       interval_ms = '1;
      default: interval_ms = $urandom_range(0, 30000);
    endcase
    case ($urandom_range(0, 5))
      0:       active_ms = '0;
      1:       active_ms = '1;
      default: active_ms = $urandom_range(0, 20000);
    endcase
    for (int s = 0; s < 5; s++) begin
      case ($urandom_range(0, 15))
        0:       secs[12*s +: 12] = 12'hFFF;
        1:       secs[12*s +: 12] = '0;
        default: secs[12*s +: 12] = 12'($urandom_range(0, 6));
      endcase
    end
    write_reg(rds_pkg::CfgKind, 64'($urandom_range(0, 3)));
    write_reg(rds_pkg::CfgCountMode, 64'($urandom_range(0, 3)));
    write_reg(rds_pkg::CfgStartMode, 64'($urandom_range(0, 3)));
    case ($urandom_range(0, 7))
      0:       thr = 12'h800;
      1:       thr = 12'h7FF;
      default: thr = 12'($urandom_range(0, 400));
    endcase
    write_reg(rds_pkg::CfgEndThr, 64'(thr));
    case ($urandom_range(0, 7))
      0:       thr = 12'h800;
      1:       thr = 12'h7FF;
      default: thr = 12'($urandom_range(0, 500) - 400);
    endcase
    write_reg(rds_pkg::CfgDemandThr, 64'(thr));
    case ($urandom_range(0, 7))
      0:       thr = 12'h800;
      1:       thr = 12'h7FF;
      default: thr = 12'($urandom_range(0, 500) - 300);
    endcase
    write_reg(rds_pkg::CfgFanThr, 64'(thr));
    write_reg(rds_pkg::CfgLongTimes, {active_ms, interval_ms});
    write_reg(rds_pkg::CfgPhaseSec, 64'(secs));
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_status.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    status_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.phase      = out_ch.phase_code;
      got.running    = out_ch.defrost_running;
      got.want_comp  = out_ch.want_compressor;
      got.want_heat  = out_ch.want_heater;
      got.want_cfan  = out_ch.want_condenser_fan;
      got.want_valve = out_ch.want_gas_valve;
      got.phase_s    = out_ch.phase_elapsed_s;
      got.intv_s     = out_ch.interval_elapsed_s;
      got.cause      = out_ch.end_cause;
      got.done       = out_ch.cycles_done;
      got.streak     = out_ch.timeouts_in_row;
      got.alarm      = out_ch.timeout_alarm;
      if (expected_status.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, phase_code %0d", got.phase));
      end else begin
        check_status(got, expected_status.pop_front());
      end
      if (got.phase <= rds_pkg::PhFan) phase_seen[got.phase] = 1'b1;
      results_checked++;
    end
  end

  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = (sink_hold != 0) ? sink_hold : $urandom_range(0, sink_max);
      sink_hold = 0;
      if (stall != 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  initial begin
    tick_t t;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_ch.valid              = 1'b0;
    in_ch.elapsed_ms         = '0;
    in_ch.evap_temperature   = '0;
    in_ch.evap_sensor_good   = 1'b0;
    in_ch.compressor_running = 1'b0;
    in_ch.protection_lockout = 1'b0;
    in_ch.manual_request     = 1'b0;

    script.push_back(typed_row(mk_tick(0, 0, 1, 0, 0, 0), rds_pkg::PhIdle, 0,
                               rds_pkg::CauseNone, 0));
    script.push_back(typed_row(mk_tick(65535, -2048, 1, 0, 0, 0), rds_pkg::PhIdle, 65,
                               rds_pkg::CauseNone, 0));
    script.push_back(typed_row(mk_tick(1000, 2047, 0, 1, 1, 0), rds_pkg::PhIdle, 66,
                               rds_pkg::CauseNone, 0));
    script.push_back(write_row(rds_pkg::CfgStartMode, 64'(rds_pkg::StartNone)));
    script.push_back(typed_row(mk_tick(500, 2047, 1, 1, 0, 1), rds_pkg::PhActive, 0,
                               rds_pkg::CauseNone, 0));
    script.push_back(tick_row(mk_tick(65535, 2047, 0, 0, 0, 0)));
    script.push_back(tick_row(mk_tick(0, 79, 1, 0, 0, 0)));
    script.push_back(typed_row(mk_tick(0, 80, 1, 0, 0, 0), rds_pkg::PhDrip, 0,
                               rds_pkg::CauseTemp, 1));
    script.push_back(typed_row(mk_tick(2000, 0, 1, 0, 1, 0), rds_pkg::PhIdle, 0,
                               rds_pkg::CauseTemp, 1));
    script.push_back(write_row(rds_pkg::CfgKind, 64'(rds_pkg::KindHotGas)));
    script.push_back(write_row(rds_pkg::CfgPhaseSec, '0));
    script.push_back(write_row(rds_pkg::CfgLongTimes, '0));
    script.push_back(tick_row(mk_tick(0, 0, 1, 0, 0, 1)));
    script.push_back(tick_row(mk_tick(0, 0, 1, 0, 0, 0)));
    script.push_back(tick_row(mk_tick(0, 0, 1, 0, 0, 0)));
    script.push_back(tick_row(mk_tick(300, -2048, 1, 1, 0, 0)));
    script.push_back(tick_row(mk_tick(0, 0, 1, 0, 0, 0)));
    script.push_back(tick_row(mk_tick(0, 0, 1, 0, 0, 0)));
    script.push_back(tick_row(mk_tick(100, -2048, 1, 0, 0, 0)));
    script.push_back(write_row(rds_pkg::CfgStartMode, 64'(rds_pkg::StartDemand)));
    script.push_back(write_row(rds_pkg::CfgCountMode, 64'(CountCompressor)));
    script.push_back(tick_row(mk_tick(100, -300, 1, 0, 0, 0)));
    script.push_back(tick_row(mk_tick(0, 0, 1, 0, 1, 0)));
    script.push_back(write_row(rds_pkg::CfgStartMode, 64'(rds_pkg::StartBoth)));
    script.push_back(tick_row(mk_tick(3000, 500, 1, 1, 0, 0)));
    script.push_back(write_row(rds_pkg::CfgKind, 64'(KindSpare)));
    script.push_back(tick_row(mk_tick(0, 0, 0, 0, 0, 1)));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_write) begin
        drain_results();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        send_tick(script[i].tick, script[i].typed, script[i].want);
      end
    end
    drain_results();

    // timeout streak run at full rate
    send_max = 0;
    sink_max = 0;
    write_reg(rds_pkg::CfgKind, 64'(KindSpare));
    write_reg(rds_pkg::CfgStartMode, 64'(rds_pkg::StartNone));
    write_reg(rds_pkg::CfgLongTimes, '0);
    write_reg(rds_pkg::CfgPhaseSec, '0);
    repeat (260) begin
      send_tick(mk_tick(0, 0, 0, 0, 0, 1), 1'b0, '0);
      send_tick(mk_tick(10, 0, 0, 0, 0, 0), 1'b0, '0);
      send_tick(mk_tick(0, 0, 0, 0, 1, 0), 1'b0, '0);
    end
    drain_results();

    for (int p = 0; p < 10; p++) begin
      pick_settings();
      send_max = (p % 4 == 1) ? 0 : 13;
      sink_max = (p % 4 == 3) ? 0 : 13;
      if (p == 2) begin
        send_max = 0;
        sink_hold = 400;
      end
      repeat (75) begin
        case ($urandom_range(0, 9))
          0:       t.dt = '0;
          1:       t.dt = 16'hFFFF;
          2:       t.dt = 16'($urandom());
          default: t.dt = 16'($urandom_range(0, 2500));
        endcase
        case ($urandom_range(0, 9))
          0:       t.temp = 12'($urandom());
          1, 2:    t.temp = 12'($urandom_range(0, 2000) - 500);
          default: t.temp = 12'($urandom_range(0, 800) - 400);
        endcase
        t.sensor_ok = ($urandom_range(0, 7) != 0);
        t.comp_on   = 1'($urandom_range(0, 1));
        t.lockout   = ($urandom_range(0, 31) == 0);
        t.manual    = ($urandom_range(0, 15) == 0);
        send_tick(t, 1'b0, '0);
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    $display("Drove %0d ticks and checked %0d results across %0d register writes.",
             ticks_sent, results_checked, reg_writes);
    $display("Phase codes reached (bit per code): %b; timeout streak driven to its ceiling.",
             phase_seen);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
